>>> src/ripc_pkg.sv
// ripc_pkg: shared constants and types of the rand index pair counter
// no dependencies; imported by ripc_table, ripc_result and the top level
`default_nettype none

package ripc_pkg;

   // default sizes of labels and counts
   localparam int LABEL_BITS_DEF   = 8;
   localparam int COUNT_BITS_DEF   = 24;

   // fixed field widths of the channels
   localparam int LABEL_FIELD_BITS = 8;
   localparam int N_OUT_BITS       = 24;
   localparam int SUM_BITS         = 48;
   localparam int PAIR_BITS        = 47;
   localparam int REQ_DATA_BITS    = 16;
   localparam int RSP_DATA_BITS    = 264;
   localparam int RSP_USED_BITS    = N_OUT_BITS + 3 * SUM_BITS + 2 * PAIR_BITS;
   localparam int RSP_PAD_BITS     = RSP_DATA_BITS - RSP_USED_BITS;

   // stack tag kept beside every table entry
   localparam int EPOCH_BITS       = 4;

   // results that may be in flight in the finishing pipeline
   localparam int RESULT_SLOTS     = 4;

   localparam logic [SUM_BITS-1:0]  SUM_MAX  = '1;
   localparam logic [PAIR_BITS-1:0] PAIR_MAX = '1;

   // per-beat control shared by the three count tables
   typedef struct packed {
      logic                  rd_en;      // beat accepted, read its entry
      logic                  upd;        // beat in update stage is counted
      logic                  stack_end;  // last beat of a stack in update stage
      logic                  sweep_en;   // clearing pass writes zero entries
      logic [EPOCH_BITS-1:0] epoch;      // tag of the current stack
   } tbl_ctrl_type;

endpackage

`default_nettype wire

>>> src/ripc_ram.sv
// ripc_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module ripc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/ripc_table.sv
// ripc_table: one count table with its running sum of squared counts
// depends on ripc_pkg and ripc_ram
`default_nettype none

module ripc_table
   import ripc_pkg::*;
#(
   parameter int ADDR_BITS  = 8,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tbl_ctrl_type         ctrl,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   input  wire logic [ADDR_BITS-1:0] sweep_addr,
   output logic      [SUM_BITS-1:0]  sum_next,
   output logic                      sat
);

   localparam int WORD_BITS = EPOCH_BITS + COUNT_BITS;

   logic [ADDR_BITS-1:0]  addr_ff;
   logic                  fwd_valid_ff, fwd_valid_in;
   logic [ADDR_BITS-1:0]  fwd_addr_ff;
   logic [COUNT_BITS-1:0] fwd_count_ff;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;

   logic [WORD_BITS-1:0]  rd_word, wr_word;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic                  wr_en;
   logic [COUNT_BITS-1:0] cur_count, new_count;
   logic                  count_max;
   logic [SUM_BITS:0]     sum_add;
   logic                  sum_ovf;

   ripc_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (1 << ADDR_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // entry value: last write wins over a read that raced it, stale tag reads zero
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == addr_ff)) begin
         cur_count = fwd_count_ff;
      end else if (rd_word[WORD_BITS-1:COUNT_BITS] == ctrl.epoch) begin
         cur_count = rd_word[COUNT_BITS-1:0];
      end else begin
         cur_count = '0;
      end
      count_max = (cur_count == '1);
      new_count = count_max ? cur_count : cur_count + 1'b1;
      // adding 2n+1 raises the sum of squares by one step
      sum_add   = {1'b0, sum_ff} + (SUM_BITS + 1)'({cur_count, 1'b1});
      sum_ovf   = sum_add[SUM_BITS];

      if (!ctrl.upd || count_max) begin
         sum_next = sum_ff;
      end else if (sum_ovf) begin
         sum_next = SUM_MAX;
      end else begin
         sum_next = sum_add[SUM_BITS-1:0];
      end
      sat = ctrl.upd && (count_max || sum_ovf);

      wr_en   = ctrl.sweep_en || ctrl.upd;
      wr_addr = ctrl.sweep_en ? sweep_addr : addr_ff;
      wr_word = ctrl.sweep_en ? {ctrl.epoch, {COUNT_BITS{1'b0}}} : {ctrl.epoch, new_count};

      sum_in       = ctrl.stack_end ? '0 : sum_next;
      fwd_valid_in = ctrl.stack_end ? 1'b0 : (ctrl.upd ? 1'b1 : fwd_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         addr_ff <= rd_addr;
      end
      if (ctrl.upd) begin
         fwd_addr_ff  <= addr_ff;
         fwd_count_ff <= new_count;
      end
   end

endmodule

`default_nettype wire

>>> src/ripc_result.sv
// ripc_result: finishing pipeline for one stack result (square, pair counts, output register)
// depends on ripc_pkg
`default_nettype none

module ripc_result
   import ripc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     cap,
   input  wire logic [COUNT_BITS-1:0]    n_in,
   input  wire logic [SUM_BITS-1:0]      rec_sum_in,
   input  wire logic [SUM_BITS-1:0]      gt_sum_in,
   input  wire logic [SUM_BITS-1:0]      pair_sum_in,
   input  wire logic                     ovf_in,
   output logic                          room,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                          rsp_tuser
);

   localparam int NN_BITS  = 2 * COUNT_BITS;
   localparam int POS_BITS = ((NN_BITS > SUM_BITS + 1) ? NN_BITS : SUM_BITS + 1) + 1;

   logic                  r1_v_ff, r1_v_in, r2_v_ff, r2_v_in, r3_v_ff, r3_v_in, out_v_in;
   logic [COUNT_BITS-1:0] r1_n_ff, r2_n_ff, r3_n_ff;
   logic [SUM_BITS-1:0]   r1_sa_ff, r1_sb_ff, r1_sc_ff;
   logic [SUM_BITS-1:0]   r2_sa_ff, r2_sb_ff, r2_sc_ff;
   logic [SUM_BITS-1:0]   r3_sa_ff, r3_sb_ff, r3_sc_ff;
   logic                  r1_o_ff, r2_o_ff, r3_o_ff;
   logic [NN_BITS-1:0]    r2_nn_ff, r2_nn_in;
   logic [POS_BITS-1:0]   r3_pos_ff, r3_neg_ff, r3_tot_ff;
   logic [POS_BITS-1:0]   r3_pos_in, r3_neg_in, r3_tot_in;

   logic                  adv_o, adv3, adv2;
   logic [2:0]            used;
   logic [POS_BITS:0]     diff;
   logic [POS_BITS-2:0]   agree_half, tot_half;
   logic [PAIR_BITS-1:0]  agree, total;

   always_comb begin
      adv_o = r3_v_ff && (!rsp_tvalid || rsp_tready);
      adv3  = r2_v_ff && (!r3_v_ff || adv_o);
      adv2  = r1_v_ff && (!r2_v_ff || adv3);

      r1_v_in  = cap ? 1'b1 : (adv2 ? 1'b0 : r1_v_ff);
      r2_v_in  = adv2 ? 1'b1 : (adv3 ? 1'b0 : r2_v_ff);
      r3_v_in  = adv3 ? 1'b1 : (adv_o ? 1'b0 : r3_v_ff);
      out_v_in = adv_o ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid);

      used = 3'(r1_v_ff) + 3'(r2_v_ff) + 3'(r3_v_ff) + 3'(rsp_tvalid) + 3'(cap);
      room = (used < 3'(RESULT_SLOTS));

      r2_nn_in  = r1_n_ff * r1_n_ff;
      r3_pos_in = POS_BITS'(r2_nn_ff) + POS_BITS'({r2_sc_ff, 1'b0});
      r3_neg_in = POS_BITS'(r2_n_ff) + POS_BITS'(r2_sa_ff) + POS_BITS'(r2_sb_ff);
      r3_tot_in = POS_BITS'(r2_nn_ff - NN_BITS'(r2_n_ff));

      // agreeing pairs clamp at zero when saturated counts make it negative
      diff       = {1'b0, r3_pos_ff} - {1'b0, r3_neg_ff};
      agree_half = diff[POS_BITS-1:1];
      tot_half   = r3_tot_ff[POS_BITS-1:1];
      if (diff[POS_BITS]) begin
         agree = '0;
      end else if (agree_half[POS_BITS-2:PAIR_BITS] != '0) begin
         agree = PAIR_MAX;
      end else begin
         agree = agree_half[PAIR_BITS-1:0];
      end
      if (tot_half[POS_BITS-2:PAIR_BITS] != '0) begin
         total = PAIR_MAX;
      end else begin
         total = tot_half[PAIR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_v_ff    <= 1'b0;
         r2_v_ff    <= 1'b0;
         r3_v_ff    <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else begin
         r1_v_ff    <= r1_v_in;
         r2_v_ff    <= r2_v_in;
         r3_v_ff    <= r3_v_in;
         rsp_tvalid <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cap) begin
         r1_n_ff  <= n_in;
         r1_sa_ff <= rec_sum_in;
         r1_sb_ff <= gt_sum_in;
         r1_sc_ff <= pair_sum_in;
         r1_o_ff  <= ovf_in;
      end
      if (adv2) begin
         r2_n_ff  <= r1_n_ff;
         r2_sa_ff <= r1_sa_ff;
         r2_sb_ff <= r1_sb_ff;
         r2_sc_ff <= r1_sc_ff;
         r2_o_ff  <= r1_o_ff;
         r2_nn_ff <= r2_nn_in;
      end
      if (adv3) begin
         r3_n_ff   <= r2_n_ff;
         r3_sa_ff  <= r2_sa_ff;
         r3_sb_ff  <= r2_sb_ff;
         r3_sc_ff  <= r2_sc_ff;
         r3_o_ff   <= r2_o_ff;
         r3_pos_ff <= r3_pos_in;
         r3_neg_ff <= r3_neg_in;
         r3_tot_ff <= r3_tot_in;
      end
      if (adv_o) begin
         rsp_tdata <= {{RSP_PAD_BITS{1'b0}}, total, agree, r3_sc_ff, r3_sb_ff, r3_sa_ff,
                       N_OUT_BITS'(r3_n_ff)};
         rsp_tuser <= r3_o_ff;
      end
   end

   // the request side only lets a last beat through when a slot is guaranteed
   a_capture_fits: assert property (@(posedge clock) disable iff (reset)
      cap |-> (!r1_v_ff || adv2))
      else $error("result captured into an occupied first stage");

endmodule

`default_nettype wire

>>> src/rand_index_pair_counter_unit.sv
// rand_index_pair_counter_unit: top level of the rand index pair counter
// depends on ripc_pkg, ripc_table (with ripc_ram) and ripc_result
//
// usage
//   req_* carries one voxel per beat: reconstruction label, ground-truth label
//   and tlast on the final voxel of a stack. csr_wr_en/csr_wr_data write the
//   ignore_background bit; write it only while the block is idle.
//   rsp_* carries one beat per stack, produced by the beat with tlast set:
//   voxel count, the three sums of squared counts, agreeing and total pairs,
//   and the overflow flag in tuser.
// throughput and pipeline
//   one voxel per cycle while req_tready is high; every table reads, modifies
//   and writes back its entry, the last write forwarded to a read that raced it.
//   a stack result moves from the update stage through r1, r2, r3 to rsp_*.
//   up to 4 results may wait in the finishing pipeline; voxels keep flowing
//   while rsp_tready is low until that pipeline is full.
// reset and stack clearing
//   each table entry carries a 4-bit stack tag; an entry from an older stack
//   reads as zero, so a stack end needs no clearing. after reset and every 16th
//   stack a clearing pass over all 2^(2*LABEL_BITS) table addresses (65536 by default)
//   zeroes the tables; req_tready is low during it.
`default_nettype none

module rand_index_pair_counter_unit
   import ripc_pkg::*;
#(
   parameter int LABEL_BITS = LABEL_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // configuration
   input  wire logic                     csr_wr_en,
   input  wire logic                     csr_wr_data,   // ignore_background
   // voxel stream
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,     // rec_label[7:0], gt_label[15:8]
   input  wire logic                     req_tlast,     // last voxel of the stack
   // result stream
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // num_locations[23:0], rec_same_pairs[71:24], gt_same_pairs[119:72],
   // both_same_pairs[167:120], agreeing_pairs[214:168], total_pairs[261:215], zero pad
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                          rsp_tuser      // overflow
);

   localparam int PAIR_ADDR_BITS = 2 * LABEL_BITS;

   // configuration
   logic                      ignore_ff;

   // update stage
   logic                      s1_valid_ff, s1_skip_ff, s1_last_ff;
   logic                      accept, skip_in, upd, stack_end, wrap;
   logic [LABEL_BITS-1:0]     rec_idx, gt_idx;

   // per-stack counters
   logic [COUNT_BITS-1:0]     vc_ff, vc_in, vc_next;
   logic                      vc_max;
   logic                      sat_ff, sat_in, sat_next;
   logic [EPOCH_BITS-1:0]     epoch_ff, epoch_in;

   // clearing pass
   logic                      sweep_active_ff, sweep_active_in, sweep_done;
   logic [PAIR_ADDR_BITS-1:0] sweep_addr_ff, sweep_addr_in;

   tbl_ctrl_type              tbl_ctrl;
   logic [SUM_BITS-1:0]       pair_sum, rec_sum, gt_sum;
   logic                      pair_sat, rec_sat, gt_sat;
   logic                      room;

   // labels keep only their low LABEL_BITS bits; the skip test looks at all 8
   assign rec_idx = LABEL_BITS'(req_tdata[LABEL_FIELD_BITS-1:0]);
   assign gt_idx  = LABEL_BITS'(req_tdata[2*LABEL_FIELD_BITS-1:LABEL_FIELD_BITS]);
   assign skip_in = ignore_ff && (req_tdata[2*LABEL_FIELD_BITS-1:LABEL_FIELD_BITS] == '0);

   // hold input while clearing, before a tag wrap, or when results could pile up
   assign req_tready = !sweep_active_ff && !wrap && room;
   assign accept     = req_tvalid && req_tready;

   assign upd       = s1_valid_ff && !s1_skip_ff;
   assign stack_end = s1_valid_ff && s1_last_ff;
   assign wrap      = stack_end && (epoch_ff == '1);

   always_comb begin
      tbl_ctrl.rd_en     = accept;
      tbl_ctrl.upd       = upd;
      tbl_ctrl.stack_end = stack_end;
      tbl_ctrl.sweep_en  = sweep_active_ff;
      tbl_ctrl.epoch     = epoch_ff;
   end

   ripc_table #(
      .ADDR_BITS  (PAIR_ADDR_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_pair_tbl (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (tbl_ctrl),
      .rd_addr    ({rec_idx, gt_idx}),
      .sweep_addr (sweep_addr_ff),
      .sum_next   (pair_sum),
      .sat        (pair_sat)
   );

   ripc_table #(
      .ADDR_BITS  (LABEL_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_rec_tbl (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (tbl_ctrl),
      .rd_addr    (rec_idx),
      .sweep_addr (sweep_addr_ff[LABEL_BITS-1:0]),
      .sum_next   (rec_sum),
      .sat        (rec_sat)
   );

   ripc_table #(
      .ADDR_BITS  (LABEL_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_gt_tbl (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (tbl_ctrl),
      .rd_addr    (gt_idx),
      .sweep_addr (sweep_addr_ff[LABEL_BITS-1:0]),
      .sum_next   (gt_sum),
      .sat        (gt_sat)
   );

   // voxel count, overflow flag and stack tag
   always_comb begin
      vc_max   = (vc_ff == '1);
      vc_next  = (upd && !vc_max) ? vc_ff + 1'b1 : vc_ff;
      sat_next = sat_ff || (upd && vc_max) || pair_sat || rec_sat || gt_sat;
      vc_in    = stack_end ? '0 : vc_next;
      sat_in   = stack_end ? 1'b0 : sat_next;
      epoch_in = stack_end ? epoch_ff + 1'b1 : epoch_ff;

      sweep_done      = sweep_active_ff && (sweep_addr_ff == '1);
      sweep_active_in = wrap ? 1'b1 : (sweep_done ? 1'b0 : sweep_active_ff);
      sweep_addr_in   = sweep_active_ff ? sweep_addr_ff + 1'b1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_ff       <= 1'b0;
         s1_valid_ff     <= 1'b0;
         vc_ff           <= '0;
         sat_ff          <= 1'b0;
         epoch_ff        <= '0;
         sweep_active_ff <= 1'b1;
         sweep_addr_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            ignore_ff <= csr_wr_data;
         end
         s1_valid_ff     <= accept;
         vc_ff           <= vc_in;
         sat_ff          <= sat_in;
         epoch_ff        <= epoch_in;
         sweep_active_ff <= sweep_active_in;
         sweep_addr_ff   <= sweep_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_skip_ff <= skip_in;
         s1_last_ff <= req_tlast;
      end
   end

   ripc_result #(
      .COUNT_BITS (COUNT_BITS)
   ) u_result (
      .clock       (clock),
      .reset       (reset),
      .cap         (stack_end),
      .n_in        (vc_next),
      .rec_sum_in  (rec_sum),
      .gt_sum_in   (gt_sum),
      .pair_sum_in (pair_sum),
      .ovf_in      (sat_next),
      .room        (room),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // no voxel may enter while the tables are being cleared
   a_no_beat_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_active_ff |-> !accept)
      else $error("voxel accepted during clearing pass");

   // running out of stack tags starts a clearing pass under tag zero
   a_wrap_sweeps: assert property (@(posedge clock) disable iff (reset)
      wrap |=> (sweep_active_ff && (epoch_ff == '0) && (sweep_addr_ff == '0)))
      else $error("tag wrap did not start a clearing pass");

   // a clearing pass ends after its last entry and never leaves a voxel behind
   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      sweep_done |=> (!sweep_active_ff && !s1_valid_ff))
      else $error("clearing pass did not end on its last entry");

endmodule

`default_nettype wire

>>> dv/tb_rand_index_pair_counter_unit.sv
// tb_rand_index_pair_counter_unit: self-checking bench for the rand index pair counter
// depends on ripc_pkg and rand_index_pair_counter_unit; voxel stacks go in, per-stack
// totals are predicted at acceptance and compared field by field with each result beat
`timescale 1ns / 1ps

module tb_rand_index_pair_counter_unit;
   import ripc_pkg::*;

   typedef longint unsigned u64_t;

   localparam int   HALF_PERIOD   = 5;
   localparam int   RESET_CYCLES  = 6;
   localparam int   VOXEL_TARGET  = 1200;
   localparam int   SETTLE_CYCLES = 12;
   // a clearing pass holds req_tready low over all 65536 pair entries; allow well beyond it
   localparam int   STALL_LIMIT   = 250000;
   localparam int unsigned COUNT_LIMIT = (1 << COUNT_BITS_DEF) - 1;
   localparam u64_t SUM_LIMIT    = (u64_t'(1) << SUM_BITS) - 1;
   localparam u64_t PAIR_LIMIT   = (u64_t'(1) << PAIR_BITS) - 1;

   typedef struct packed {
      logic [LABEL_FIELD_BITS-1:0] rec;
      logic [LABEL_FIELD_BITS-1:0] gt;
      logic                        last;
   } voxel_t;

   typedef struct packed {
      logic [N_OUT_BITS-1:0] num_locations;
      logic [SUM_BITS-1:0]   rec_same;
      logic [SUM_BITS-1:0]   gt_same;
      logic [SUM_BITS-1:0]   both_same;
      logic [PAIR_BITS-1:0]  agreeing;
      logic [PAIR_BITS-1:0]  total;
      logic                  overflow;
   } stack_totals_t;

   // dut ports; the driven inputs are known from time zero
   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     csr_wr_en   = 1'b0;
   logic                     csr_wr_data = 1'b0;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic                     req_tlast   = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;

   // predictor state: count tables, running sums and the register copy
   int unsigned   pair_tally[int unsigned];
   int unsigned   rec_tally[256];
   int unsigned   gt_tally[256];
   int unsigned   voxels;
   u64_t          rec_sq_sum, gt_sq_sum, pair_sq_sum;
   bit            saturated;
   bit            ignore_bg_model;

   voxel_t        voxel_backlog[$];
   stack_totals_t expected_totals[$];
   int            voxels_queued;
   int            mismatches;
   int            idle_cycles;

   // driver and monitor pacing
   voxel_t        next_voxel;
   int            req_gap;
   bit            req_calm;
   int            rsp_hold;
   bit            rsp_calm;
   stack_totals_t got_totals;
   stack_totals_t want_totals;

   rand_index_pair_counter_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #HALF_PERIOD clock = ~clock;

   // one table entry goes from n to n+1, its square sum grows by 2n+1
   function automatic void raise_tally(inout int unsigned tally, inout u64_t square_sum);
      u64_t step;
      if (tally >= COUNT_LIMIT) begin
         saturated = 1'b1;
      end else begin
         step = u64_t'(tally);
         step = 2 * step + 1;
         tally++;
         if (square_sum > SUM_LIMIT - step) begin
            square_sum = SUM_LIMIT;
            saturated  = 1'b1;
         end else begin
            square_sum += step;
         end
      end
   endfunction

   // accepted voxel: update the tables, on the last one queue the stack totals
   function automatic void count_voxel(input voxel_t vx);
      int unsigned   key;
      int unsigned   tally;
      u64_t          n, pos, neg, agree, total;
      stack_totals_t res;
      key = 32'({vx.rec, vx.gt});
      if (!(ignore_bg_model && vx.gt == '0)) begin
         if (voxels >= COUNT_LIMIT) saturated = 1'b1;
         else voxels++;
         tally = pair_tally.exists(key) ? pair_tally[key] : 0;
         raise_tally(tally, pair_sq_sum);
         pair_tally[key] = tally;
         tally = rec_tally[vx.rec];
         raise_tally(tally, rec_sq_sum);
         rec_tally[vx.rec] = tally;
         tally = gt_tally[vx.gt];
         raise_tally(tally, gt_sq_sum);
         gt_tally[vx.gt] = tally;
      end
      if (vx.last) begin
         n     = u64_t'(voxels);
         pos   = n * n + 2 * pair_sq_sum;
         neg   = n + rec_sq_sum + gt_sq_sum;
         // only saturated counts can make the numerator negative
         agree = (pos > neg) ? (pos - neg) / 2 : 0;
         if (agree > PAIR_LIMIT) agree = PAIR_LIMIT;
         total = (n == 0) ? 0 : (n * (n - 1)) / 2;
         if (total > PAIR_LIMIT) total = PAIR_LIMIT;
         res.num_locations = n[N_OUT_BITS-1:0];
         res.rec_same      = rec_sq_sum[SUM_BITS-1:0];
         res.gt_same       = gt_sq_sum[SUM_BITS-1:0];
         res.both_same     = pair_sq_sum[SUM_BITS-1:0];
         res.agreeing      = agree[PAIR_BITS-1:0];
         res.total         = total[PAIR_BITS-1:0];
         res.overflow      = saturated;
         expected_totals.push_back(res);
         // the stack is done, every table starts over
         pair_tally.delete();
         foreach (rec_tally[i]) rec_tally[i] = 0;
         foreach (gt_tally[i]) gt_tally[i] = 0;
         voxels      = 0;
         rec_sq_sum  = 0;
         gt_sq_sum   = 0;
         pair_sq_sum = 0;
         saturated   = 1'b0;
      end
   endfunction

   function automatic void check_field(input string name, input u64_t want, input u64_t got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // mostly short gaps, a few long ones, and calm stretches with none at all
   function automatic int draw_gap(inout bit calm);
      int r;
      if ($urandom_range(0, 63) == 0) calm = ~calm;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // driver: predict on each accepted beat, then present the next voxel
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    = 0;
      end else begin
         if (req_tvalid && req_tready)
            count_voxel('{rec: req_tdata[7:0], gt: req_tdata[15:8], last: req_tlast});
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (voxel_backlog.size() > 0) begin
               next_voxel = voxel_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {next_voxel.gt, next_voxel.rec};
               req_tlast  <= next_voxel.last;
               req_gap    = draw_gap(req_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result beat against the oldest expected totals
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_totals.num_locations = rsp_tdata[23:0];
            got_totals.rec_same      = rsp_tdata[71:24];
            got_totals.gt_same       = rsp_tdata[119:72];
            got_totals.both_same     = rsp_tdata[167:120];
            got_totals.agreeing      = rsp_tdata[214:168];
            got_totals.total         = rsp_tdata[261:215];
            got_totals.overflow      = rsp_tuser;
            if (expected_totals.size() == 0) begin
               $display("%0t ns: result beat with none expected, num_locations %0d",
                        $time, got_totals.num_locations);
               mismatches++;
            end else begin
               want_totals = expected_totals.pop_front();
               check_field("num_locations", want_totals.num_locations,
                           got_totals.num_locations);
               check_field("rec_same_pairs", want_totals.rec_same, got_totals.rec_same);
               check_field("gt_same_pairs", want_totals.gt_same, got_totals.gt_same);
               check_field("both_same_pairs", want_totals.both_same, got_totals.both_same);
               check_field("agreeing_pairs", want_totals.agreeing, got_totals.agreeing);
               check_field("total_pairs", want_totals.total, got_totals.total);
               check_field("overflow", want_totals.overflow, got_totals.overflow);
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_hold   = draw_gap(rsp_calm);
         end
      end
   end

   // watchdog: too long without any beat on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_voxel(input logic [7:0] rec, input logic [7:0] gt, input logic last);
      voxel_backlog.push_back('{rec: rec, gt: gt, last: last});
      voxels_queued++;
   endtask

   // register write between stacks; no voxel or result is in flight here
   task automatic write_ignore_bg(input bit value);
      @(posedge clock);
      csr_wr_en       <= 1'b1;
      csr_wr_data     <= value;
      ignore_bg_model = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // every queued voxel accepted and every stack result back, then a short settle
   task automatic wait_for_totals();
      @(negedge clock);
      while (voxel_backlog.size() > 0 || req_tvalid || expected_totals.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one stack of random content; flavors give clustered, scattered or agreeing labels
   task automatic queue_random_stack();
      int         len, flavor, bg_pct;
      logic [7:0] base_rec, base_gt, rec, gt;
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 150) : $urandom_range(1, 30);
      flavor   = $urandom_range(0, 2);
      base_rec = 8'($urandom_range(0, 255));
      base_gt  = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
         0:       bg_pct = 100;   // all background, empty when ignored
         1, 2:    bg_pct = 40;
         3, 4, 5: bg_pct = 10;
         default: bg_pct = 0;
      endcase
      for (int i = 0; i < len; i++) begin
         case (flavor)
            0: begin
               rec = base_rec + 8'($urandom_range(0, 3));
               gt  = base_gt + 8'($urandom_range(0, 3));
            end
            1: begin
               rec = 8'($urandom_range(0, 255));
               gt  = 8'($urandom_range(0, 255));
            end
            default: begin
               rec = base_rec + 8'($urandom_range(0, 5));
               gt  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : rec ^ base_gt;
            end
         endcase
         if ($urandom_range(0, 99) < bg_pct) gt = 8'd0;
         push_voxel(rec, gt, i == len - 1);
      end
   endtask

   initial begin
      bit ignore_next;
      mismatches    = 0;
      voxels_queued = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // background counted: single-voxel stack, label extremes, bit patterns
      write_ignore_bg(1'b0);
      push_voxel(8'd0, 8'd0, 1'b1);
      push_voxel(8'd255, 8'd255, 1'b0);
      push_voxel(8'd0, 8'd255, 1'b0);
      push_voxel(8'd255, 8'd0, 1'b0);
      push_voxel(8'd0, 8'd0, 1'b0);
      push_voxel(8'd255, 8'd255, 1'b1);
      push_voxel(8'hAA, 8'h55, 1'b0);
      push_voxel(8'h55, 8'hAA, 1'b0);
      push_voxel(8'hAA, 8'h55, 1'b1);
      wait_for_totals();

      // background ignored: empty stack, skipped last voxel, background mid-stack
      write_ignore_bg(1'b1);
      push_voxel(8'd3, 8'd0, 1'b1);
      push_voxel(8'd5, 8'd7, 1'b0);
      push_voxel(8'd5, 8'd7, 1'b0);
      push_voxel(8'd9, 8'd0, 1'b0);
      push_voxel(8'd9, 8'd0, 1'b1);
      push_voxel(8'd255, 8'd0, 1'b0);
      push_voxel(8'd0, 8'd1, 1'b0);
      push_voxel(8'd255, 8'd255, 1'b1);
      wait_for_totals();

      // random phases, the register flips between them
      ignore_next = 1'b0;
      while (voxels_queued < VOXEL_TARGET) begin
         write_ignore_bg(ignore_next);
         repeat ($urandom_range(2, 6)) queue_random_stack();
         wait_for_totals();
         ignore_next = ~ignore_next;
      end

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/ripc_pkg.sv
src/ripc_ram.sv
src/ripc_table.sv
src/ripc_result.sv
src/rand_index_pair_counter_unit.sv
dv/tb_rand_index_pair_counter_unit.sv
